// ----- hdl/vc3_pkg.sv -----
`default_nettype none
package vc3_pkg;

  localparam int unsigned CoordW      = 16;
  localparam int unsigned CosFracBits = 15;
  localparam int unsigned CosW        = CosFracBits + 1;
  localparam int unsigned ProdW       = 2 * CoordW;
  localparam int unsigned SqrtW       = 2 * CoordW;
  localparam int unsigned RadW        = 4 * CoordW;

  typedef struct packed {
    logic signed [CoordW-1:0] a_x;
    logic signed [CoordW-1:0] a_y;
    logic signed [CoordW-1:0] a_z;
    logic signed [CoordW-1:0] b_x;
    logic signed [CoordW-1:0] b_y;
    logic signed [CoordW-1:0] b_z;
  } vc3_in_t;

  typedef struct packed {
    logic signed [CosW-1:0] cosine;
    logic                   zero_norm;
  } vc3_out_t;

  // per-item sideband that rides along the sqrt and divide pipes
  typedef struct packed {
    logic             zero;
    logic             neg;
    logic [SqrtW-1:0] dmag;
  } vc3_side_t;

endpackage
`default_nettype wire

// ----- hdl/vc3_mult.sv -----
`default_nettype none
module vc3_mult (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               adv_i,
  input  wire logic               valid_i,
  input  wire vc3_pkg::vc3_in_t   req_i,
  output logic                    valid_o,
  output logic [vc3_pkg::RadW-1:0] rad_o,
  output vc3_pkg::vc3_side_t      side_o
);
  import vc3_pkg::*;

  // stage 1: nine products
  logic                      v1_q;
  logic signed [ProdW-1:0]   dx_q, dy_q, dz_q;
  logic signed [ProdW-1:0]   sax_q, say_q, saz_q, sbx_q, sby_q, sbz_q;
  // stage 2: sums
  logic                      v2_q;
  logic [ProdW-1:0]          na2_q, nb2_q;
  vc3_side_t                 side2_q;
  // stage 3: partial products of the norm product
  logic                      v3_q;
  logic [ProdW-1:0]          phh_q, phl_q, plh_q, pll_q;
  vc3_side_t                 side3_q;
  // stage 4: full radicand
  logic                      v4_q;
  logic [RadW-1:0]           rad_q;
  vc3_side_t                 side4_q;

  logic signed [ProdW:0]     dot_d;
  logic [ProdW-1:0]          na2_d, nb2_d;
  vc3_side_t                 side2_d;
  logic [RadW-1:0]           rad_d;

  always_comb begin
    dot_d = {dx_q[ProdW-1], dx_q} + {dy_q[ProdW-1], dy_q} + {dz_q[ProdW-1], dz_q};
    na2_d = ProdW'(sax_q) + ProdW'(say_q) + ProdW'(saz_q);
    nb2_d = ProdW'(sbx_q) + ProdW'(sby_q) + ProdW'(sbz_q);
    side2_d.zero = (na2_d == '0) || (nb2_d == '0);
    side2_d.neg  = dot_d[ProdW];
    side2_d.dmag = dot_d[ProdW] ? SqrtW'(-dot_d) : SqrtW'(dot_d);
    rad_d = {phh_q, {ProdW{1'b0}}}
          + (RadW'({1'b0, phl_q} + {1'b0, plh_q}) << CoordW)
          + RadW'(pll_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (adv_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      dx_q  <= req_i.a_x * req_i.b_x;
      dy_q  <= req_i.a_y * req_i.b_y;
      dz_q  <= req_i.a_z * req_i.b_z;
      sax_q <= req_i.a_x * req_i.a_x;
      say_q <= req_i.a_y * req_i.a_y;
      saz_q <= req_i.a_z * req_i.a_z;
      sbx_q <= req_i.b_x * req_i.b_x;
      sby_q <= req_i.b_y * req_i.b_y;
      sbz_q <= req_i.b_z * req_i.b_z;

      na2_q   <= na2_d;
      nb2_q   <= nb2_d;
      side2_q <= side2_d;

      phh_q   <= na2_q[ProdW-1:CoordW] * nb2_q[ProdW-1:CoordW];
      phl_q   <= na2_q[ProdW-1:CoordW] * nb2_q[CoordW-1:0];
      plh_q   <= na2_q[CoordW-1:0] * nb2_q[ProdW-1:CoordW];
      pll_q   <= na2_q[CoordW-1:0] * nb2_q[CoordW-1:0];
      side3_q <= side2_q;

      rad_q   <= rad_d;
      side4_q <= side3_q;
    end
  end

  assign valid_o = v4_q;
  assign rad_o   = rad_q;
  assign side_o  = side4_q;

endmodule
`default_nettype wire

// ----- hdl/vc3_sqrt.sv -----
`default_nettype none
module vc3_sqrt (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 adv_i,
  input  wire logic                 valid_i,
  input  wire logic [vc3_pkg::RadW-1:0] rad_i,
  input  wire vc3_pkg::vc3_side_t   side_i,
  output logic                      valid_o,
  output logic [vc3_pkg::SqrtW-1:0] root_o,
  output vc3_pkg::vc3_side_t        side_o
);
  import vc3_pkg::*;

  localparam int unsigned RemW = SqrtW + 3;

  // one result bit per stage, two radicand bits consumed per stage
  logic [SqrtW:0]   v_w;
  logic [RadW-1:0]  x_w    [SqrtW+1];
  logic [RemW-1:0]  rem_w  [SqrtW+1];
  logic [SqrtW-1:0] root_w [SqrtW+1];
  vc3_side_t        side_w [SqrtW+1];

  assign v_w[0]    = valid_i;
  assign x_w[0]    = rad_i;
  assign rem_w[0]  = '0;
  assign root_w[0] = '0;
  assign side_w[0] = side_i;

  for (genvar k = 0; k < SqrtW; k++) begin : g_stage
    logic             v_q;
    logic [RadW-1:0]  x_q;
    logic [RemW-1:0]  rem_q;
    logic [SqrtW-1:0] root_q;
    vc3_side_t        side_q;
    logic [RemW-1:0]  rem_sh, trial;
    logic             ge;

    always_comb begin
      rem_sh = {rem_w[k][RemW-3:0], x_w[k][RadW-1 -: 2]};
      trial  = RemW'({root_w[k], 2'b01});
      ge     = rem_sh >= trial;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q <= 1'b0;
      end else if (adv_i) begin
        v_q <= v_w[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        x_q    <= {x_w[k][RadW-3:0], 2'b00};
        rem_q  <= ge ? rem_sh - trial : rem_sh;
        root_q <= {root_w[k][SqrtW-2:0], ge};
        side_q <= side_w[k];
      end
    end

    assign v_w[k+1]    = v_q;
    assign x_w[k+1]    = x_q;
    assign rem_w[k+1]  = rem_q;
    assign root_w[k+1] = root_q;
    assign side_w[k+1] = side_q;
  end

  assign valid_o = v_w[SqrtW];
  assign root_o  = root_w[SqrtW];
  assign side_o  = side_w[SqrtW];

endmodule
`default_nettype wire

// ----- hdl/vc3_div.sv -----
`default_nettype none
module vc3_div (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       adv_i,
  input  wire logic                       valid_i,
  input  wire logic [vc3_pkg::SqrtW-1:0]  root_i,
  input  wire vc3_pkg::vc3_side_t         side_i,
  output logic                            valid_o,
  output logic [vc3_pkg::CosFracBits-1:0] quo_o,
  output logic                            sat_o,
  output vc3_pkg::vc3_side_t              side_o
);
  import vc3_pkg::*;

  // setup stage: full-scale check, then one quotient bit per stage
  logic             v0_q;
  logic [SqrtW-1:0] r0_q, s0_q;
  logic             sat0_q;
  vc3_side_t        side0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (adv_i) begin
      v0_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      r0_q    <= side_i.dmag;
      s0_q    <= root_i;
      sat0_q  <= side_i.dmag >= root_i;
      side0_q <= side_i;
    end
  end

  logic [CosFracBits:0]   v_w;
  logic [SqrtW-1:0]       r_w    [CosFracBits+1];
  logic [SqrtW-1:0]       s_w    [CosFracBits+1];
  logic [CosFracBits-1:0] q_w    [CosFracBits+1];
  logic [CosFracBits:0]   sat_w;
  vc3_side_t              side_w [CosFracBits+1];

  assign v_w[0]    = v0_q;
  assign r_w[0]    = r0_q;
  assign s_w[0]    = s0_q;
  assign q_w[0]    = '0;
  assign sat_w[0]  = sat0_q;
  assign side_w[0] = side0_q;

  for (genvar k = 0; k < CosFracBits; k++) begin : g_stage
    logic                   v_q;
    logic [SqrtW-1:0]       r_q, s_q;
    logic [CosFracBits-1:0] q_q;
    logic                   sat_q;
    vc3_side_t              side_q;
    logic [SqrtW:0]         r_sh, r_sub;
    logic                   ge;

    always_comb begin
      r_sh  = {r_w[k], 1'b0};
      r_sub = r_sh - {1'b0, s_w[k]};
      ge    = r_sh >= {1'b0, s_w[k]};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q <= 1'b0;
      end else if (adv_i) begin
        v_q <= v_w[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        r_q    <= ge ? r_sub[SqrtW-1:0] : r_sh[SqrtW-1:0];
        s_q    <= s_w[k];
        q_q    <= {q_w[k][CosFracBits-2:0], ge};
        sat_q  <= sat_w[k];
        side_q <= side_w[k];
      end
    end

    assign v_w[k+1]    = v_q;
    assign r_w[k+1]    = r_q;
    assign s_w[k+1]    = s_q;
    assign q_w[k+1]    = q_q;
    assign sat_w[k+1]  = sat_q;
    assign side_w[k+1] = side_q;
  end

  assign valid_o = v_w[CosFracBits];
  assign quo_o   = q_w[CosFracBits];
  assign sat_o   = sat_w[CosFracBits];
  assign side_o  = side_w[CosFracBits];

endmodule
`default_nettype wire

// ----- hdl/vector_cosine_3d.sv -----
// cosine of the angle between two 3-component signed vectors, Q1.15 out
//
// input channel: in_valid_i / in_ready_o with the request in in_req_i
// (a_x..b_z); output channel: out_valid_o / out_ready_i with out_rsp_o
// (cosine, zero_norm). one response per request, in request order.
//
// each request passes through the multiply and sum stages, the bit-serial
// square root (one root bit per stage), a setup stage and 15 divide stages
// (one quotient bit per stage), and the output register. a new request is
// taken every cycle while the pipe advances.
//
// the whole pipe moves together: it advances whenever the output register
// is empty or being taken, so a stalled receiver freezes every stage and
// holds in_ready_o low; nothing is dropped or repeated.
// reset clears all stage valid bits; the pipe is empty afterwards.
// a zero-length vector gives zero_norm = 1 and cosine = 0; exactly
// parallel vectors saturate to +32767.
`default_nettype none
module vector_cosine_3d (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire vc3_pkg::vc3_in_t  in_req_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output vc3_pkg::vc3_out_t      out_rsp_o
);
  import vc3_pkg::*;

  logic                   adv;
  logic                   m_valid, s_valid, d_valid;
  logic [RadW-1:0]        m_rad;
  vc3_side_t              m_side, s_side, d_side;
  logic [SqrtW-1:0]       s_root;
  logic [CosFracBits-1:0] d_quo;
  logic                   d_sat;

  logic                   out_valid_q;
  vc3_out_t               rsp_q, rsp_d;
  logic [CosW-1:0]        qfull;

  assign adv        = !out_valid_q || out_ready_i;
  assign in_ready_o = adv;

  vc3_mult u_mult (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (in_valid_i),
    .req_i   (in_req_i),
    .valid_o (m_valid),
    .rad_o   (m_rad),
    .side_o  (m_side)
  );

  vc3_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (m_valid),
    .rad_i   (m_rad),
    .side_i  (m_side),
    .valid_o (s_valid),
    .root_o  (s_root),
    .side_o  (s_side)
  );

  vc3_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (s_valid),
    .root_i  (s_root),
    .side_i  (s_side),
    .valid_o (d_valid),
    .quo_o   (d_quo),
    .sat_o   (d_sat),
    .side_o  (d_side)
  );

  always_comb begin
    qfull = d_sat ? {1'b1, {CosFracBits{1'b0}}} : {1'b0, d_quo};
    rsp_d.zero_norm = d_side.zero;
    if (d_side.zero) begin
      rsp_d.cosine = '0;
    end else if (d_side.neg) begin
      rsp_d.cosine = -qfull;
    end else if (d_sat) begin
      // cosine of exactly one saturates
      rsp_d.cosine = {1'b0, {CosFracBits{1'b1}}};
    end else begin
      rsp_d.cosine = {1'b0, d_quo};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= d_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rsp_q <= rsp_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = rsp_q;

`ifndef SYNTHESIS
  a_zero_gives_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.zero_norm |-> out_rsp_o.cosine == '0)
    else $error("zero-norm response with nonzero cosine");

  a_no_stall_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o || out_ready_i |-> in_ready_o)
    else $error("pipe stalled while output register is free");

  a_stall_holds_rsp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |=> out_valid_o && $stable(out_rsp_o))
    else $error("stalled pipe changed its output");
`endif

endmodule
`default_nettype wire

// ----- tb/vector_cosine_3d_tb.sv -----
`default_nettype none
module vector_cosine_3d_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import vc3_pkg::*;

  localparam int unsigned NumRandom = 1850;
  localparam int unsigned Latency   = 53;
  localparam longint unsigned CycleLimit = 400000;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     in_valid_i = 1'b0;
  logic     in_ready_o;
  vc3_in_t  in_req_i = '0;
  logic     out_valid_o;
  logic     out_ready_i = 1'b0;
  vc3_out_t out_rsp_o;

  vector_cosine_3d u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_rsp_o  (out_rsp_o)
  );

  always #5 clk_i = ~clk_i;

  vc3_in_t  pending_reqs[$];
  vc3_out_t expected_cos[$];
  int unsigned n_errors = 0;
  int unsigned n_sent = 0;
  int unsigned n_checked = 0;
  int unsigned n_total = 0;
  int unsigned n_zero = 0;
  int unsigned n_sat = 0;
  longint unsigned n_cycles = 0;

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch %0s at response %0d: got %0d want %0d", what, n_checked, got, want);
    n_errors++;
  endtask

  // exact integer cosine: floor(|dot| * 2^15 / floor(sqrt(na2*nb2))), signed by dot, clamped to Q1.15
  function automatic vc3_out_t cosine_of(input vc3_in_t r);
    longint dot;
    longint unsigned na2, nb2, dmag, q, rem;
    logic [127:0] prod, c;
    logic [63:0] root;
    vc3_out_t res;
    dot = longint'(r.a_x) * r.b_x + longint'(r.a_y) * r.b_y + longint'(r.a_z) * r.b_z;
    na2 = longint'(r.a_x) * r.a_x + longint'(r.a_y) * r.a_y + longint'(r.a_z) * r.a_z;
    nb2 = longint'(r.b_x) * r.b_x + longint'(r.b_y) * r.b_y + longint'(r.b_z) * r.b_z;
    res = '0;
    if (na2 == 0 || nb2 == 0) begin
      res.zero_norm = 1'b1;
      return res;
    end
    prod = 128'(na2) * 128'(nb2);
    root = '0;
    for (int b = 63; b >= 0; b--) begin
      c = 128'(root | (64'd1 << b));
      if (c * c <= prod) root = root | (64'd1 << b);
    end
    dmag = dot < 0 ? longint'(-dot) : longint'(dot);
    if (dmag >= root) begin
      q = 64'd1 << CosFracBits;
    end else begin
      q = 0;
      rem = dmag;
      for (int i = 0; i < CosFracBits; i++) begin
        rem = rem << 1;
        q = q << 1;
        if (rem >= root) begin
          rem = rem - root;
          q = q | 1;
        end
      end
    end
    if (dot < 0) begin
      res.cosine = CosW'(-q);
    end else begin
      if (q >= (64'd1 << CosFracBits)) q = (64'd1 << CosFracBits) - 1;
      res.cosine = CosW'(q);
    end
    return res;
  endfunction

  function automatic logic signed [CoordW-1:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      1: return CoordW'($urandom_range(0, 6)) - 16'sd3;
      2: return CoordW'($urandom_range(0, 511)) - 16'sd256;
      default: return CoordW'($urandom());
    endcase
  endfunction

  task automatic add_req(input vc3_in_t r);
    pending_reqs.push_back(r);
  endtask

  function automatic vc3_in_t make_vec(input logic signed [CoordW-1:0] ax, ay, az, bx, by, bz);
    vc3_in_t r;
    r = '{a_x: ax, a_y: ay, a_z: az, b_x: bx, b_y: by, b_z: bz};
    return r;
  endfunction

  initial begin
    vc3_in_t r;
    int k;
    add_req(make_vec(0, 0, 0, 1, 2, 3));
    add_req(make_vec(5, -7, 9, 0, 0, 0));
    add_req(make_vec(0, 0, 0, 0, 0, 0));
    add_req(make_vec(3, 4, 5, 3, 4, 5));
    add_req(make_vec(3, 4, 5, -3, -4, -5));
    add_req(make_vec(1, 2, 3, 2, 4, 6));
    add_req(make_vec(1, 0, 0, 0, 1, 0));
    add_req(make_vec(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff));
    add_req(make_vec(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000));
    add_req(make_vec(16'sh8000, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh7fff));
    add_req(make_vec(16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000));
    add_req(make_vec(16'sh8000, 0, 0, 16'sh8000, 0, 0));
    add_req(make_vec(16'sh8000, 0, 0, 16'sh7fff, 0, 0));
    add_req(make_vec(-1, -1, -1, 1, 1, 1));
    add_req(make_vec(1, 1, 0, 1, 0, 0));
    add_req(make_vec(16'sh7fff, 1, 0, 1, 16'sh7fff, 0));
    add_req(make_vec(-1, 16'shffff, -1, -1, -1, -1));
    for (k = 0; k < NumRandom; k++) begin
      r = make_vec(rand_coord(), rand_coord(), rand_coord(),
                   rand_coord(), rand_coord(), rand_coord());
      case ($urandom_range(0, 9))
        0: r.b_x = r.a_x;   // shared x component
        1: begin
          // scaled copy gives parallel or antiparallel vectors
          r.b_x = r.a_x >>> 1; r.b_y = r.a_y >>> 1; r.b_z = r.a_z >>> 1;
          r.a_x = r.b_x <<< 1; r.a_y = r.b_y <<< 1; r.a_z = r.b_z <<< 1;
          if ($urandom_range(0, 1)) begin
            r.b_x = -r.b_x; r.b_y = -r.b_y; r.b_z = -r.b_z;
          end
        end
        2: begin
          r.a_x = '0; r.a_y = '0; r.a_z = '0;
        end
        3: begin
          r.b_x = '0; r.b_y = '0; r.b_z = '0;
        end
        default: ;
      endcase
      add_req(r);
    end
    n_total = pending_reqs.size();
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
  end

  // sender: bursts with random gaps
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  bit in_taken = 1'b0;
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_taken) begin
        // still waiting for acceptance
      end else if (gap_left > 0) begin
        in_valid_i <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending_reqs.size() > 0) begin
        in_req_i   <= pending_reqs.pop_front();
        in_valid_i <= 1'b1;
        if (burst_left == 0) begin
          burst_left <= $urandom_range(1, 40);
        end else if (burst_left == 1) begin
          burst_left <= 0;
          gap_left <= $urandom_range(0, 3) == 0 ? $urandom_range(0, 20) : 0;
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    in_taken <= rst_ni && in_valid_i && in_ready_o;
    if (rst_ni && in_valid_i && in_ready_o) begin
      expected_cos.push_back(cosine_of(in_req_i));
      n_sent <= n_sent + 1;
    end
  end

  // receiver: stall pattern of its own
  int unsigned stall_phase = 0;
  always @(negedge clk_i) begin
    stall_phase <= stall_phase + 1;
    case ((stall_phase >> 8) % 4)
      0: out_ready_i <= 1'b1;
      1: out_ready_i <= $urandom_range(0, 3) != 0;
      2: out_ready_i <= (stall_phase % 7) < 3;
      default: out_ready_i <= $urandom_range(0, 1) != 0;
    endcase
  end

  always @(posedge clk_i) begin
    vc3_out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_cos.size() == 0) begin
        report_mismatch("unexpected response", out_rsp_o.cosine, 0);
      end else begin
        want = expected_cos.pop_front();
        if (out_rsp_o.cosine !== want.cosine)
          report_mismatch("cosine", out_rsp_o.cosine, want.cosine);
        if (out_rsp_o.zero_norm !== want.zero_norm)
          report_mismatch("zero_norm", out_rsp_o.zero_norm, want.zero_norm);
        if (want.zero_norm) n_zero++;
        if (want.cosine == 16'sh7fff || want.cosine == 16'sh8000) n_sat++;
      end
      n_checked++;
    end
  end

  always @(posedge clk_i) begin
    n_cycles <= n_cycles + 1;
    if (n_cycles >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d responses pending", n_cycles,
               expected_cos.size());
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    wait (rst_ni);
    wait (n_checked >= n_total);
    repeat (Latency + 10) @(posedge clk_i);
    $display("sent %0d requests, checked %0d responses", n_sent, n_checked);
    $display("zero-length cases %0d, full-scale cosines %0d", n_zero, n_sat);
    if (n_errors == 0 && expected_cos.size() == 0 && n_checked == n_total &&
        n_sent == n_total) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
`default_nettype wire
